// ===== rtl/core/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and the control store of the PID balance drive.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Widths
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned DIFF_W     = 18;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 21;
  localparam int unsigned PROD_W     = 55;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned DVD_W      = 64;
  localparam int unsigned DVS_W      = 20;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DRIVE_W    = 9;

  localparam logic [DVS_W-1:0] US_PER_S = 20'd1000000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;

  // Divider runs two quotient bits per cycle
  localparam int unsigned DIV_LONG_CYC  = DVD_W / 2;
  localparam int unsigned DIV_SHORT_CYC = 21;
  localparam logic [CNT_W-1:0] DIV_LONG_LAST  = CNT_W'(DIV_LONG_CYC - 1);
  localparam logic [CNT_W-1:0] DIV_SHORT_LAST = CNT_W'(DIV_SHORT_CYC - 1);

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 3'd5;

  localparam logic [15:0] RST_SETPOINT  = 16'd0;
  localparam logic [15:0] RST_GAIN_P    = 16'd7424;
  localparam logic [15:0] RST_GAIN_I    = 16'd51;
  localparam logic [15:0] RST_GAIN_D    = 16'd166;
  localparam logic [15:0] RST_INT_LIMIT = 16'd25856;
  localparam logic [7:0]  RST_DEAD_BAND = 8'd60;

  // Program steps
  localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_EDT  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIV_INT  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_WAIT_INT = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ACC      = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_I    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_P    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MUL_D    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MUL_US   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DIV_D    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_WAIT_D   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_ADD_D    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DRIVE    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_OUT      = 4'd13;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_DT,
    MUL_GI_ACC,
    MUL_GP_ERR,
    MUL_GD_DIFF,
    MUL_PROD_US
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IN_WAIT,
    COND_DIV_WAIT,
    COND_DT_ZERO,
    COND_OUT_WAIT,
    COND_JUMP
  } cond_e;

  typedef enum logic [1:0] {
    SUM_NONE,
    SUM_LOAD_PROD,
    SUM_ADD_PROD_SH8,
    SUM_ADD_QUOT
  } sum_op_e;

  typedef struct packed {
    logic              in_ready;
    mul_sel_e          mul_sel;
    logic              div_start;
    logic              div_long;
    logic              acc_upd;
    sum_op_e           sum_op;
    logic              drive_upd;
    logic              out_load;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic dt_zero;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic [15:0]        integral_limit;
    logic [7:0]         dead_band;
  } cfg_t;

  // Control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    c.mul_sel = MUL_NONE;
    c.sum_op  = SUM_NONE;
    c.cond    = COND_NEXT;
    c.target  = STEP_FETCH;
    unique case (step)
      STEP_FETCH: begin
        c.in_ready = 1'b1;
        c.cond     = COND_IN_WAIT;
      end
      STEP_MUL_EDT:  c.mul_sel = MUL_ERR_DT;
      STEP_DIV_INT:  c.div_start = 1'b1;
      STEP_WAIT_INT: c.cond = COND_DIV_WAIT;
      STEP_ACC:      c.acc_upd = 1'b1;
      STEP_MUL_I:    c.mul_sel = MUL_GI_ACC;
      STEP_MUL_P: begin
        c.mul_sel = MUL_GP_ERR;
        c.sum_op  = SUM_LOAD_PROD;
      end
      STEP_MUL_D: begin
        c.mul_sel = MUL_GD_DIFF;
        c.sum_op  = SUM_ADD_PROD_SH8;
      end
      STEP_MUL_US: begin
        c.mul_sel = MUL_PROD_US;
        c.cond    = COND_DT_ZERO;
        c.target  = STEP_DRIVE;
      end
      STEP_DIV_D: begin
        c.div_start = 1'b1;
        c.div_long  = 1'b1;
      end
      STEP_WAIT_D: begin
        c.div_long = 1'b1;
        c.cond     = COND_DIV_WAIT;
      end
      STEP_ADD_D:  c.sum_op = SUM_ADD_QUOT;
      STEP_DRIVE:  c.drive_upd = 1'b1;
      STEP_OUT: begin
        c.out_load = 1'b1;
        c.cond     = COND_OUT_WAIT;
        c.target   = STEP_FETCH;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = STEP_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/pbd_divider.sv =====
// ----------------------------------------------------------------------------
// pbd_divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pbd_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           long_i,
  input  logic [pbd_pkg::DVD_W-1:0]      dividend_i,
  input  logic [pbd_pkg::DVS_W-1:0]      divisor_i,
  output logic                           busy_o,
  output logic [pbd_pkg::DVD_W-1:0]      quot_o
);

  logic                         busy_q, busy_d;
  logic [pbd_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [pbd_pkg::DVS_W-1:0]    rem_q, rem_d;
  logic [pbd_pkg::DVS_W-1:0]    dvs_q, dvs_d;
  logic [pbd_pkg::DVD_W-1:0]    sh_q, sh_d;
  logic [pbd_pkg::DVS_W:0]      st1, st2;

  // Returns {quotient bit, new remainder}
  function automatic logic [pbd_pkg::DVS_W:0] div_step(
    input logic [pbd_pkg::DVS_W-1:0] rem,
    input logic                      bit_in,
    input logic [pbd_pkg::DVS_W-1:0] dvs
  );
    logic [pbd_pkg::DVS_W:0] t;
    logic [pbd_pkg::DVS_W:0] r;
    t = {rem, bit_in};
    if (t >= {1'b0, dvs}) begin
      r = t - {1'b0, dvs};
      return {1'b1, r[pbd_pkg::DVS_W-1:0]};
    end else begin
      return {1'b0, t[pbd_pkg::DVS_W-1:0]};
    end
  endfunction

  assign st1 = div_step(rem_q, sh_q[pbd_pkg::DVD_W-1], dvs_q);
  assign st2 = div_step(st1[pbd_pkg::DVS_W-1:0], sh_q[pbd_pkg::DVD_W-2], dvs_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = long_i ? pbd_pkg::DIV_LONG_LAST : pbd_pkg::DIV_SHORT_LAST;
      rem_d  = '0;
      dvs_d  = divisor_i;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = st2[pbd_pkg::DVS_W-1:0];
      sh_d  = {sh_q[pbd_pkg::DVD_W-3:0], st1[pbd_pkg::DVS_W], st2[pbd_pkg::DVS_W]};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;

endmodule

// ===== rtl/core/pbd_sequencer.sv =====
// ----------------------------------------------------------------------------
// pbd_sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
module pbd_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbd_pkg::seq_status_t  status_i,
  output pbd_pkg::ctrl_t        ctrl_o
);

  logic [pbd_pkg::STEP_W-1:0] step_q, step_d;
  logic [pbd_pkg::STEP_W-1:0] step_inc;
  pbd_pkg::ctrl_t             ctrl;

  assign ctrl     = pbd_pkg::ucode(step_q);
  assign step_inc = step_q + 1'b1;

  always_comb begin
    unique case (ctrl.cond)
      pbd_pkg::COND_NEXT:     step_d = step_inc;
      pbd_pkg::COND_IN_WAIT:  step_d = status_i.in_valid ? step_inc : step_q;
      pbd_pkg::COND_DIV_WAIT: step_d = status_i.div_busy ? step_q : step_inc;
      pbd_pkg::COND_DT_ZERO:  step_d = status_i.dt_zero ? ctrl.target : step_inc;
      pbd_pkg::COND_OUT_WAIT: step_d = status_i.out_busy ? step_q : ctrl.target;
      pbd_pkg::COND_JUMP:     step_d = ctrl.target;
      default:                step_d = pbd_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pbd_pkg::STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ===== rtl/core/pbd_datapath.sv =====
// ----------------------------------------------------------------------------
// pbd_datapath
// Error, integral, shared multiplier, term accumulator and drive saturation.
// ----------------------------------------------------------------------------
module pbd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbd_pkg::ctrl_t                    ctrl_i,
  input  pbd_pkg::cfg_t                     cfg_i,
  input  logic                              in_accept_i,
  input  logic signed [15:0]                tilt_angle_i,
  input  logic [15:0]                       delta_us_i,
  input  logic [pbd_pkg::DVD_W-1:0]         quot_i,
  output logic [pbd_pkg::DVD_W-1:0]         dividend_o,
  output logic [pbd_pkg::DVS_W-1:0]         divisor_o,
  output logic                              dt_zero_o,
  output logic signed [pbd_pkg::DRIVE_W-1:0] drive_o
);

  localparam int unsigned QI_W = 22;

  logic signed [pbd_pkg::ERR_W-1:0]   err_q, err_d, prev_err_q;
  logic signed [pbd_pkg::DIFF_W-1:0]  diff_q, diff_d;
  logic [15:0]                        dt_q;
  logic signed [pbd_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic signed [pbd_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic                               quot_neg_q;
  logic signed [pbd_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic signed [pbd_pkg::DRIVE_W-1:0] drive_q, drive_d;

  logic signed [pbd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pbd_pkg::MUL_B_W-1:0] mul_b;
  logic [pbd_pkg::PROD_W-1:0]         prod_mag;

  logic signed [pbd_pkg::ACC_W+1:0]   acc_step, acc_sum, acc_lim;
  logic signed [pbd_pkg::SUM_W-1:0]   prod_ext, quot_s;
  logic signed [39:0]                 drive_raw;

  // Error and error change, formed as the item is taken
  assign err_d  = {cfg_i.setpoint[15], cfg_i.setpoint} - {tilt_angle_i[15], tilt_angle_i};
  assign diff_d = {err_d[pbd_pkg::ERR_W-1], err_d} - {prev_err_q[pbd_pkg::ERR_W-1], prev_err_q};

  always_comb begin
    case (ctrl_i.mul_sel)
      pbd_pkg::MUL_ERR_DT: begin
        mul_a = {{17{err_q[pbd_pkg::ERR_W-1]}}, err_q};
        mul_b = {5'b0, dt_q};
      end
      pbd_pkg::MUL_GI_ACC: begin
        mul_a = {{9{acc_q[pbd_pkg::ACC_W-1]}}, acc_q};
        mul_b = {5'b0, cfg_i.gain_i};
      end
      pbd_pkg::MUL_GP_ERR: begin
        mul_a = {{17{err_q[pbd_pkg::ERR_W-1]}}, err_q};
        mul_b = {5'b0, cfg_i.gain_p};
      end
      pbd_pkg::MUL_GD_DIFF: begin
        mul_a = {{16{diff_q[pbd_pkg::DIFF_W-1]}}, diff_q};
        mul_b = {5'b0, cfg_i.gain_d};
      end
      pbd_pkg::MUL_PROD_US: begin
        mul_a = prod_q[pbd_pkg::MUL_A_W-1:0];
        mul_b = {1'b0, pbd_pkg::US_PER_S};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Sign-magnitude division gives truncation toward zero
  assign prod_mag   = prod_q[pbd_pkg::PROD_W-1] ? pbd_pkg::PROD_W'(-prod_q) : prod_q;
  assign dividend_o = ctrl_i.div_long ? {1'b0, prod_mag, 8'b0}
                                      : {prod_mag[33:0], 8'b0, 22'b0};
  assign divisor_o  = ctrl_i.div_long ? {4'b0, dt_q} : pbd_pkg::US_PER_S;
  assign dt_zero_o  = (dt_q == '0);

  // Integral with clamp
  always_comb begin
    acc_step = quot_neg_q ? -$signed({5'b0, quot_i[QI_W-1:0]})
                          :  $signed({5'b0, quot_i[QI_W-1:0]});
    acc_sum  = {{2{acc_q[pbd_pkg::ACC_W-1]}}, acc_q} + acc_step;
    acc_lim  = $signed({3'b0, cfg_i.integral_limit, 8'b0});
    if (acc_sum > acc_lim) begin
      acc_d = pbd_pkg::ACC_W'(acc_lim);
    end else if (acc_sum < -acc_lim) begin
      acc_d = pbd_pkg::ACC_W'(-acc_lim);
    end else begin
      acc_d = pbd_pkg::ACC_W'(acc_sum);
    end
  end

  // Term accumulator
  assign prod_ext = {{9{prod_q[pbd_pkg::PROD_W-1]}}, prod_q};
  assign quot_s   = quot_neg_q ? -$signed(quot_i) : $signed(quot_i);

  always_comb begin
    case (ctrl_i.sum_op)
      pbd_pkg::SUM_LOAD_PROD:    sum_d = prod_ext;
      pbd_pkg::SUM_ADD_PROD_SH8: sum_d = sum_q + (prod_ext <<< 8);
      pbd_pkg::SUM_ADD_QUOT:     sum_d = sum_q + quot_s;
      default:                   sum_d = sum_q;
    endcase
  end

  // Scale down by 2^24 toward zero, then saturate
  always_comb begin
    drive_raw = sum_q[pbd_pkg::SUM_W-1:24]
              + {39'b0, sum_q[pbd_pkg::SUM_W-1] & (|sum_q[23:0])};
    if (drive_raw > 40'sd255) begin
      drive_d = pbd_pkg::DRIVE_MAX;
    end else if (drive_raw < -40'sd255) begin
      drive_d = -pbd_pkg::DRIVE_MAX;
    end else begin
      drive_d = drive_raw[pbd_pkg::DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      acc_q      <= '0;
    end else begin
      if (in_accept_i) begin
        prev_err_q <= err_d;
      end
      if (ctrl_i.acc_upd) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      err_q  <= err_d;
      diff_q <= diff_d;
      dt_q   <= delta_us_i;
    end
    if (ctrl_i.mul_sel != pbd_pkg::MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.div_start) begin
      quot_neg_q <= prod_q[pbd_pkg::PROD_W-1];
    end
    sum_q <= sum_d;
    if (ctrl_i.drive_upd) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

// ===== rtl/core/pid_balance_drive.sv =====
// ----------------------------------------------------------------------------
// pid_balance_drive
// PID balance controller with integral clamp and deadband motor direction.
// ----------------------------------------------------------------------------
// Item accept to result valid is paced mostly by the divider, at two bits per
// cycle: it runs for the integral step and, unless delta_us is zero, for the
// derivative.
// Throughput: one item per program pass, held while the output register is stalled;
// the next item is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; clears integral, previous error, program
// step, output valid and loads the default register values.
module pid_balance_drive (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // tilt_angle[15:0], delta_us[31:16]
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata   // drive_value[8:0],
                                                           // forward_duty[16:9],
                                                           // backward_duty[24:17]
);

  pbd_pkg::cfg_t         cfg_q;
  pbd_pkg::ctrl_t        ctrl;
  pbd_pkg::seq_status_t  status;

  logic                               in_accept;
  logic                               out_busy;
  logic                               out_load;
  logic                               div_busy;
  logic                               dt_zero;
  logic [pbd_pkg::DVD_W-1:0]          quot;
  logic [pbd_pkg::DVD_W-1:0]          dividend;
  logic [pbd_pkg::DVS_W-1:0]          divisor;
  logic signed [pbd_pkg::DRIVE_W-1:0] drive;

  logic                               out_valid_q, out_valid_d;
  logic [pbd_pkg::DRIVE_W-1:0]        out_drive_q;
  logic [7:0]                         out_fwd_q, out_fwd_d;
  logic [7:0]                         out_bwd_q, out_bwd_d;
  logic signed [pbd_pkg::DRIVE_W:0]   drive_ext, db_ext;
  logic [pbd_pkg::DRIVE_W-1:0]        drive_neg;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint       <= pbd_pkg::RST_SETPOINT;
      cfg_q.gain_p         <= pbd_pkg::RST_GAIN_P;
      cfg_q.gain_i         <= pbd_pkg::RST_GAIN_I;
      cfg_q.gain_d         <= pbd_pkg::RST_GAIN_D;
      cfg_q.integral_limit <= pbd_pkg::RST_INT_LIMIT;
      cfg_q.dead_band      <= pbd_pkg::RST_DEAD_BAND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pbd_pkg::REG_SETPOINT:  cfg_q.setpoint       <= cfg_data_i;
        pbd_pkg::REG_GAIN_P:    cfg_q.gain_p         <= cfg_data_i;
        pbd_pkg::REG_GAIN_I:    cfg_q.gain_i         <= cfg_data_i;
        pbd_pkg::REG_GAIN_D:    cfg_q.gain_d         <= cfg_data_i;
        pbd_pkg::REG_INT_LIMIT: cfg_q.integral_limit <= cfg_data_i;
        pbd_pkg::REG_DEAD_BAND: cfg_q.dead_band      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign s_axis_tready = ctrl.in_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign out_load      = ctrl.out_load && !out_busy;

  assign status.in_valid = s_axis_tvalid;
  assign status.div_busy = div_busy;
  assign status.dt_zero  = dt_zero;
  assign status.out_busy = out_busy;

  pbd_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  pbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .in_accept_i  (in_accept),
    .tilt_angle_i (s_axis_tdata[15:0]),
    .delta_us_i   (s_axis_tdata[31:16]),
    .quot_i       (quot),
    .dividend_o   (dividend),
    .divisor_o    (divisor),
    .dt_zero_o    (dt_zero),
    .drive_o      (drive)
  );

  pbd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .long_i     (ctrl.div_long),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Deadband direction select
  assign drive_ext = {drive[pbd_pkg::DRIVE_W-1], drive};
  assign db_ext    = $signed({2'b0, cfg_q.dead_band});
  assign drive_neg = -drive;

  always_comb begin
    out_fwd_d = '0;
    out_bwd_d = '0;
    if (drive_ext > db_ext) begin
      out_fwd_d = drive[7:0];
    end else if (drive_ext < -db_ext) begin
      out_bwd_d = drive_neg[7:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_drive_q <= drive;
      out_fwd_q   <= out_fwd_d;
      out_bwd_q   <= out_bwd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_bwd_q, out_fwd_q, out_drive_q};

endmodule

// ===== rtl/core/pbd_checker.sv =====
// ----------------------------------------------------------------------------
// pbd_checker
// Port-level checks of the PID balance drive, bound to the top level.
// ----------------------------------------------------------------------------
module pbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [8:0] drive;
  logic [7:0] fwd;
  logic [7:0] bwd;

  assign drive = m_axis_tdata[8:0];
  assign fwd   = m_axis_tdata[16:9];
  assign bwd   = m_axis_tdata[24:17];

  // One item in the program at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fwd == 8'd0) || (bwd == 8'd0))
    else $error("both duties nonzero");

  a_fwd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fwd != 8'd0) |-> drive == {1'b0, fwd})
    else $error("forward duty differs from drive");

  a_bwd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (bwd != 8'd0) |-> (drive + {1'b0, bwd}) == 9'd0)
    else $error("backward duty differs from drive magnitude");

endmodule

bind pid_balance_drive pbd_checker u_pbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pid_balance_drive. A tracker class mirrors the
// gains, setpoint, integral and last error, predicts drive value and duties
// for every accepted sample, and compares them with each result item.
// Directed corner samples come first, then randomized phases under random
// register settings with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module testbench;
  import pbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint USEC          = 1000000;
  localparam longint DRIVE_LIM     = 255;
  localparam int     PHASES        = 8;
  localparam int     PHASE_ITEMS   = 125;
  localparam int     REPORT_LIMIT  = 10;

  typedef struct {
    logic signed [8:0] drive;
    logic [7:0]        fwd;
    logic [7:0]        bwd;
  } drive_result_t;

  class balance_loop_tracker;
    logic signed [15:0] setpoint;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic [15:0]        integral_limit;
    logic [7:0]         dead_band;
    int                 integral_acc;
    int                 prev_error;
    drive_result_t      pending_drives[$];
    int                 failures;
    int                 samples;
    int                 checked;
    int                 cfg_writes;
    int                 saturated;
    int                 forward_cnt;
    int                 backward_cnt;
    int                 stopped_cnt;

    function new();
      setpoint       = RST_SETPOINT;
      gain_p         = RST_GAIN_P;
      gain_i         = RST_GAIN_I;
      gain_d         = RST_GAIN_D;
      integral_limit = RST_INT_LIMIT;
      dead_band      = RST_DEAD_BAND;
      integral_acc   = 0;
      prev_error     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      cfg_writes++;
      case (idx)
        REG_SETPOINT:  setpoint = data;
        REG_GAIN_P:    gain_p = data;
        REG_GAIN_I:    gain_i = data;
        REG_GAIN_D:    gain_d = data;
        REG_INT_LIMIT: integral_limit = data;
        REG_DEAD_BAND: dead_band = data[7:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [15:0] tilt, logic [15:0] dt);
      longint        dt_v;
      longint        err;
      longint        diff;
      longint        lim;
      longint        acc;
      longint        term_d;
      longint        sum;
      longint        drive;
      drive_result_t r;
      dt_v = longint'(dt);
      err  = longint'(setpoint) - longint'($signed(tilt));
      diff = err - longint'(prev_error);
      lim  = longint'(integral_limit) * 256;
      acc  = longint'(integral_acc) + (err * dt_v * 256) / USEC;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integral_acc = int'(acc);
      term_d = 0;
      if (dt_v != 0) term_d = (longint'(gain_d) * diff * 256 * USEC) / dt_v;
      prev_error = int'(err);
      sum = longint'(gain_p) * err * 256 + longint'(gain_i) * acc + term_d;
      drive = sum / 16777216;
      if (drive > DRIVE_LIM) drive = DRIVE_LIM;
      if (drive < -DRIVE_LIM) drive = -DRIVE_LIM;
      r.drive = drive[8:0];
      r.fwd   = '0;
      r.bwd   = '0;
      if (drive > longint'(dead_band)) begin
        r.fwd = drive[7:0];
        forward_cnt++;
      end else if (drive < -longint'(dead_band)) begin
        r.bwd = 8'(-drive);
        backward_cnt++;
      end else begin
        stopped_cnt++;
      end
      if (drive == DRIVE_LIM || drive == -DRIVE_LIM) saturated++;
      samples++;
      pending_drives.push_back(r);
    endfunction

    function void check_drive(logic [31:0] data);
      drive_result_t     r;
      logic signed [8:0] got_drive;
      logic [7:0]        got_fwd;
      logic [7:0]        got_bwd;
      got_drive = data[8:0];
      got_fwd   = data[16:9];
      got_bwd   = data[24:17];
      checked++;
      if (pending_drives.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result item with nothing pending: data=%h", data);
        return;
      end
      r = pending_drives.pop_front();
      if (got_drive !== r.drive || got_fwd !== r.fwd || got_bwd !== r.bwd) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result %0d: drive exp %0d got %0d, fwd exp %0d got %0d, bwd exp %0d got %0d",
                   checked, r.drive, got_drive, r.fwd, got_fwd, r.bwd, got_bwd);
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [31:0]             s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;

  balance_loop_tracker sb;
  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_phase   = 0;

  pid_balance_drive u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: check, then pick next stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (rx_phase % 8) == 0;
        default: m_axis_tready <= rx_left < 4;
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_done();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input logic [15:0] tilt, input logic [15:0] dt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, tilt};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_sample(tilt, dt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [15:0] pick_setting(input int typical_max);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      1, 2:    return 16'($urandom_range(0, typical_max));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apply_random_settings();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      1, 2:    v = 16'($urandom_range(0, 5120)) - 16'd2560;
      default: v = 16'($urandom);
    endcase
    write_reg(REG_SETPOINT, v);
    write_reg(REG_GAIN_P, pick_setting(16000));
    write_reg(REG_GAIN_I, pick_setting(2000));
    write_reg(REG_GAIN_D, pick_setting(1000));
    write_reg(REG_INT_LIMIT, pick_setting(40000));
    case ($urandom_range(0, 3))
      0:       v = {8'($urandom), ($urandom_range(0, 1) ? 8'hff : 8'h00)};
      1, 2:    v = 16'($urandom_range(0, 120));
      default: v = 16'($urandom);
    endcase
    write_reg(REG_DEAD_BAND, v);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    cfg_done();
  endtask

  task automatic send_random_item();
    logic [15:0] tilt;
    logic [15:0] dt;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        tilt = 16'($urandom);
        dt   = 16'($urandom);
      end
      3, 4: begin
        tilt = sb.setpoint + 16'($urandom_range(0, 6000)) - 16'd3000;
        dt   = 16'($urandom_range(1, 50));
      end
      5: begin
        tilt = 16'($urandom);
        dt   = 16'd0;
      end
      6, 7: begin
        tilt = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        dt   = $urandom_range(0, 1) ? 16'hffff : 16'($urandom);
      end
      default: begin
        tilt = sb.setpoint + 16'($urandom_range(0, 6000)) - 16'd3000;
        dt   = 16'($urandom_range(500, 20000));
      end
    endcase
    send_item(tilt, dt);
  endtask

  initial begin
    int hold_at;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset
    send_item(16'h0000, 16'd1000);
    send_item(16'h8000, 16'hffff);
    send_item(16'h7fff, 16'd1);
    send_item(16'h0000, 16'd0);
    send_item(16'h0a00, 16'd5000);
    send_item(16'hf600, 16'd5000);
    send_item(16'h0100, 16'd10000);

    // zero dead band via wide value, ignored spare indexes, setpoint top
    drain();
    write_reg(REG_DEAD_BAND, 16'hff00);
    write_reg(REG_SPARE_LO, 16'hffff);
    write_reg(REG_SPARE_HI, 16'h1234);
    write_reg(REG_SETPOINT, 16'h7fff);
    write_reg(REG_INT_LIMIT, 16'h0000);
    cfg_done();
    send_item(16'h8000, 16'hffff);
    send_item(16'h7fff, 16'd200);
    send_item(16'h7ff0, 16'd3000);
    send_item(16'h7fff, 16'd0);

    // gains and clamp at their top, setpoint at its most negative, full dead band
    drain();
    write_reg(REG_SETPOINT, 16'h8000);
    write_reg(REG_GAIN_P, 16'hffff);
    write_reg(REG_GAIN_I, 16'hffff);
    write_reg(REG_GAIN_D, 16'hffff);
    write_reg(REG_INT_LIMIT, 16'hffff);
    write_reg(REG_DEAD_BAND, 16'h00ff);
    cfg_done();
    send_item(16'h7fff, 16'd1);
    send_item(16'h8000, 16'hffff);
    send_item(16'h8001, 16'd100);
    send_item(16'h7fff, 16'd0);

    // all gains zero
    drain();
    write_reg(REG_GAIN_P, 16'h0000);
    write_reg(REG_GAIN_I, 16'h0000);
    write_reg(REG_GAIN_D, 16'h0000);
    write_reg(REG_DEAD_BAND, 16'h0000);
    cfg_done();
    send_item(16'h0000, 16'd1234);

    // integral only, small clamp
    drain();
    write_reg(REG_SETPOINT, 16'h0000);
    write_reg(REG_GAIN_I, 16'hffff);
    write_reg(REG_INT_LIMIT, 16'd50);
    write_reg(REG_DEAD_BAND, 16'd10);
    cfg_done();
    repeat (4) send_item(16'h8000, 16'hffff);
    repeat (2) send_item(16'h7fff, 16'hffff);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      apply_random_settings();
      hold_at = ($urandom_range(0, 1) == 0 || p == 0) ? $urandom_range(1, PHASE_ITEMS - 1) : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == hold_at) drain();
        send_random_item();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.failures++;
      $display("ERROR: %0d expected results never arrived", sb.pending());
    end
    $display("Covered %0d samples, %0d results checked, %0d register writes",
             sb.samples, sb.checked, sb.cfg_writes);
    $display("Outputs: %0d saturated, %0d forward, %0d backward, %0d stopped; %0d failures",
             sb.saturated, sb.forward_cnt, sb.backward_cnt, sb.stopped_cnt, sb.failures);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("ERROR: timeout with %0d results pending", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
